>>> design/pdsl_pkg.sv
// pdsl_pkg: shared types and constants for the pd drive controller
// payload structs, sequencer state enum, default parameter values
// no dependencies
package pdsl_pkg;

  localparam int unsigned POS_W      = 24;
  localparam int unsigned DRV_W      = 12;
  localparam int unsigned GAIN_W     = 10;
  localparam int unsigned SLANT_W    = 11;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam int unsigned SPEEDUP_STEP_DEF    = 9;
  localparam int unsigned DECEL_STEP_DEF      = 256;
  localparam int unsigned STILL_THRESHOLD_DEF = 3;

  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SLANT          = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_SCALE_POS = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_SCALE_NEG = 3'd7;

  typedef struct packed {
    logic signed [POS_W-1:0] left_position;
    logic signed [POS_W-1:0] right_position;
  } in_item_t;

  typedef struct packed {
    logic signed [DRV_W-1:0] left_drive;
    logic signed [DRV_W-1:0] right_drive;
    logic                    moving;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_SCALE,
    S_SP,
    S_ERR,
    S_MULP,
    S_DER,
    S_MULD,
    S_QUOT,
    S_CLAMP,
    S_REQ,
    S_SLEW
  } seq_state_t;

endpackage

>>> design/pd_drive_with_slew_limit.sv
// pd_drive_with_slew_limit: pd controller with per-side slew limiting
// and a stall detector; uses pdsl_pkg for payload types and the state enum
// single module, bit-serial multiplier over the 10-bit gain operands
//
// One input transaction is one control tick carrying both encoder positions;
// it yields exactly one output transaction with the two slew limited drive
// commands and the moving flag. The block works on one tick at a time: from
// acceptance to the result register, a tick runs through the shift-add
// multiplier that handles one gain bit per cycle, for the proportional and
// derivative products, preceded in turn mode by the turn target scaling and
// its rounding divide; the sequencer returns to idle, where the next tick can
// be accepted, as the result register loads. The result register holds one
// finished tick, so the next tick is taken while a result still waits; that
// tick then holds in its last step until the result register frees up.
// Configuration writes are always accepted (cfg_ready is tied high) and must
// only be issued while no tick is in flight.
module pd_drive_with_slew_limit #(
  parameter int unsigned SPEEDUP_STEP    = pdsl_pkg::SPEEDUP_STEP_DEF,
  parameter int unsigned DECEL_STEP      = pdsl_pkg::DECEL_STEP_DEF,
  parameter int unsigned STILL_THRESHOLD = pdsl_pkg::STILL_THRESHOLD_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  pdsl_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output pdsl_pkg::out_item_t                  out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pdsl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pdsl_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int unsigned POS_W  = pdsl_pkg::POS_W;
  localparam int unsigned DRV_W  = pdsl_pkg::DRV_W;
  localparam int unsigned GAIN_W = pdsl_pkg::GAIN_W;
  localparam int unsigned ERR_W  = 27;           // error, both modes
  localparam int unsigned DER_W  = ERR_W + 1;    // derivative term
  localparam int unsigned ACC_W  = 40;           // product accumulator
  localparam int unsigned Q_W    = ACC_W - 8;    // accumulator over 256
  localparam int unsigned SPD_W  = 11;           // clamped pd output
  localparam int unsigned REQ_W  = DRV_W + 1;    // side request
  localparam int unsigned SLW_W  = DRV_W + 2;    // slew arithmetic
  localparam int unsigned CNT_W  = 4;
  localparam int unsigned DIF_W  = POS_W + 1;

  // ---------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------
  logic                          drive_mode;
  logic signed [POS_W-1:0]       target;
  logic [GAIN_W-1:0]             gain_p;
  logic [GAIN_W-1:0]             gain_d;
  logic [GAIN_W-1:0]             max_speed;
  logic signed [pdsl_pkg::SLANT_W-1:0] slant;
  logic [GAIN_W-1:0]             turn_scale_pos;
  logic [GAIN_W-1:0]             turn_scale_neg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_mode     <= 1'b1;
      target         <= '0;
      gain_p         <= GAIN_W'(77);
      gain_d         <= GAIN_W'(128);
      max_speed      <= GAIN_W'(200);
      slant          <= '0;
      turn_scale_pos <= GAIN_W'(602);
      turn_scale_neg <= GAIN_W'(589);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pdsl_pkg::REG_DRIVE_MODE:     drive_mode     <= cfg_data[0];
        pdsl_pkg::REG_TARGET:         target         <= cfg_data[POS_W-1:0];
        pdsl_pkg::REG_GAIN_P:         gain_p         <= cfg_data[GAIN_W-1:0];
        pdsl_pkg::REG_GAIN_D:         gain_d         <= cfg_data[GAIN_W-1:0];
        pdsl_pkg::REG_MAX_SPEED:      max_speed      <= cfg_data[GAIN_W-1:0];
        pdsl_pkg::REG_SLANT:          slant          <= cfg_data[pdsl_pkg::SLANT_W-1:0];
        pdsl_pkg::REG_TURN_SCALE_POS: turn_scale_pos <= cfg_data[GAIN_W-1:0];
        pdsl_pkg::REG_TURN_SCALE_NEG: turn_scale_neg <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // datapath registers
  // ---------------------------------------------------------------
  pdsl_pkg::seq_state_t state, state_next;

  logic signed [POS_W-1:0]  lp, rp;          // latched positions
  logic signed [DIF_W-1:0]  sv;              // turn measured value
  logic [POS_W-1:0]         travel;
  logic signed [ERR_W-1:0]  sp;              // scaled turn setpoint
  logic signed [ERR_W-1:0]  err;
  logic signed [ACC_W-1:0]  acc;             // shift-add accumulator
  logic signed [ACC_W-1:0]  mcand;           // multiplicand, shifts left
  logic [GAIN_W-1:0]        mplier;          // multiplier, shifts right
  logic [CNT_W-1:0]         cnt;             // bit counter
  logic signed [Q_W-1:0]    quot;
  logic signed [SPD_W-1:0]  spd;
  logic signed [REQ_W-1:0]  lreq, rreq;

  // control state
  logic signed [ERR_W-1:0]  previous_error;
  logic signed [ERR_W-1:0]  turn_previous_error;
  logic signed [DRV_W-1:0]  left_speed, right_speed;
  logic [2:0]               still_count;
  logic [POS_W-1:0]         last_travel;
  logic signed [POS_W-1:0]  last_goal;

  // ---------------------------------------------------------------
  // combinational helpers
  // ---------------------------------------------------------------
  logic signed [DIF_W-1:0]  pos_diff;
  logic [POS_W-1:0]         abs_l, abs_r;
  logic [POS_W:0]           abs_sum;
  logic signed [ACC_W-1:0]  acc_bias;
  logic signed [ERR_W-1:0]  err_drive;
  logic signed [DER_W-1:0]  der;
  logic signed [Q_W-1:0]    lim_pos, lim_neg;
  logic signed [SLW_W-1:0]  l_next, r_next;
  logic signed [DIF_W-1:0]  trav_diff;
  logic [DIF_W-1:0]         trav_abs;
  logic                     still_tick;
  logic [2:0]               still_next;
  logic                     mul_last;
  logic                     out_free;

  // tick travel and turn measured value (truncated halves)
  assign pos_diff = DIF_W'(rp) - DIF_W'(lp);
  assign abs_l    = lp[POS_W-1] ? POS_W'(-lp) : POS_W'(lp);
  assign abs_r    = rp[POS_W-1] ? POS_W'(-rp) : POS_W'(rp);
  assign abs_sum  = {1'b0, abs_l} + {1'b0, abs_r};

  // divide by 256 toward zero
  assign acc_bias = acc + (acc[ACC_W-1] ? ACC_W'(255) : ACC_W'(0));

  assign err_drive = ERR_W'(target) - ERR_W'(lp);
  assign der = drive_mode ? (DER_W'(err) - DER_W'(previous_error))
                          : (DER_W'(err) - DER_W'(turn_previous_error));

  assign lim_pos = Q_W'(max_speed);
  assign lim_neg = -Q_W'(max_speed);

  assign mul_last = (cnt == CNT_W'(GAIN_W - 1));

  // slew toward the request, accelerating or decelerating step
  function automatic logic signed [SLW_W-1:0] slew_fn(
    input logic signed [DRV_W-1:0] cur,
    input logic signed [REQ_W-1:0] req
  );
    logic signed [SLW_W-1:0] c, r, a_c, a_r, stp;
    c   = SLW_W'(cur);
    r   = SLW_W'(req);
    a_c = c[SLW_W-1] ? -c : c;
    a_r = r[SLW_W-1] ? -r : r;
    stp = (a_c < a_r) ? SLW_W'(SPEEDUP_STEP) : SLW_W'(DECEL_STEP);
    if (r > c + stp) begin
      slew_fn = c + stp;
    end else if (r < c - stp) begin
      slew_fn = c - stp;
    end else begin
      slew_fn = r;
    end
  endfunction

  assign l_next = slew_fn(left_speed, lreq);
  assign r_next = slew_fn(right_speed, rreq);

  // stall detector: small travel change counts a still tick
  assign trav_diff  = DIF_W'(last_travel) - DIF_W'(travel);
  assign trav_abs   = trav_diff[DIF_W-1] ? DIF_W'(-trav_diff) : DIF_W'(trav_diff);
  assign still_tick = (trav_abs < DIF_W'(STILL_THRESHOLD));

  always_comb begin
    if (still_tick) begin
      still_next = (still_count < 3'd5) ? still_count + 3'd1 : still_count;
    end else begin
      still_next = '0;
    end
    if (target != last_goal) begin
      still_next = '0;
    end
  end

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == pdsl_pkg::S_IDLE);

  // ---------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pdsl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pdsl_pkg::S_IDLE:  if (in_valid) state_next = pdsl_pkg::S_PREP;
      pdsl_pkg::S_PREP:  state_next = drive_mode ? pdsl_pkg::S_ERR : pdsl_pkg::S_SCALE;
      pdsl_pkg::S_SCALE: if (mul_last) state_next = pdsl_pkg::S_SP;
      pdsl_pkg::S_SP:    state_next = pdsl_pkg::S_ERR;
      pdsl_pkg::S_ERR:   state_next = pdsl_pkg::S_MULP;
      pdsl_pkg::S_MULP:  if (mul_last) state_next = pdsl_pkg::S_DER;
      pdsl_pkg::S_DER:   state_next = pdsl_pkg::S_MULD;
      pdsl_pkg::S_MULD:  if (mul_last) state_next = pdsl_pkg::S_QUOT;
      pdsl_pkg::S_QUOT:  state_next = pdsl_pkg::S_CLAMP;
      pdsl_pkg::S_CLAMP: state_next = pdsl_pkg::S_REQ;
      pdsl_pkg::S_REQ:   state_next = pdsl_pkg::S_SLEW;
      pdsl_pkg::S_SLEW:  if (out_free) state_next = pdsl_pkg::S_IDLE;
      default:           state_next = pdsl_pkg::S_IDLE;
    endcase
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      pdsl_pkg::S_IDLE: begin
        if (in_valid) begin
          lp <= in_data.left_position;
          rp <= in_data.right_position;
        end
      end
      pdsl_pkg::S_PREP: begin
        sv     <= (pos_diff + signed'(DIF_W'(pos_diff[DIF_W-1]))) >>> 1;
        travel <= abs_sum[POS_W:1];
        acc    <= '0;
        mcand  <= ACC_W'(target);
        mplier <= (target > 0) ? turn_scale_pos : turn_scale_neg;
        cnt    <= '0;
      end
      pdsl_pkg::S_SCALE, pdsl_pkg::S_MULP, pdsl_pkg::S_MULD: begin
        if (mplier[0]) acc <= acc + mcand;
        mcand  <= mcand <<< 1;
        mplier <= mplier >> 1;
        cnt    <= cnt + CNT_W'(1);
      end
      pdsl_pkg::S_SP: begin
        sp <= ERR_W'(acc_bias >>> 8);
      end
      pdsl_pkg::S_ERR: begin
        err    <= drive_mode ? err_drive : ERR_W'(sp - ERR_W'(sv));
        mcand  <= drive_mode ? ACC_W'(err_drive) : ACC_W'(sp - ERR_W'(sv));
        mplier <= gain_p;
        acc    <= '0;
        cnt    <= '0;
      end
      pdsl_pkg::S_DER: begin
        mcand  <= ACC_W'(der);
        mplier <= gain_d;
        cnt    <= '0;
      end
      pdsl_pkg::S_QUOT: begin
        quot <= Q_W'(acc_bias >>> 8);
      end
      pdsl_pkg::S_CLAMP: begin
        if (quot > lim_pos) begin
          spd <= SPD_W'(lim_pos);
        end else if (quot < lim_neg) begin
          spd <= SPD_W'(lim_neg);
        end else begin
          spd <= SPD_W'(quot);
        end
      end
      pdsl_pkg::S_REQ: begin
        if (drive_mode) begin
          lreq <= REQ_W'(spd) - REQ_W'(slant);
          rreq <= REQ_W'(spd) + REQ_W'(slant);
        end else begin
          lreq <= -REQ_W'(spd);
          rreq <= REQ_W'(spd);
        end
      end
      default: ;
    endcase
  end

  // control state and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_error      <= '0;
      turn_previous_error <= '0;
      left_speed          <= '0;
      right_speed         <= '0;
      still_count         <= '0;
      last_travel         <= '0;
      last_goal           <= '0;
      out_valid           <= 1'b0;
    end else begin
      // each mode keeps its own previous error
      if (state == pdsl_pkg::S_DER) begin
        if (drive_mode) previous_error <= err;
        else turn_previous_error <= err;
      end
      if (state == pdsl_pkg::S_SLEW && out_free) begin
        left_speed  <= DRV_W'(l_next);
        right_speed <= DRV_W'(r_next);
        still_count <= still_next;
        last_travel <= travel;
        last_goal   <= target;
        out_valid   <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == pdsl_pkg::S_SLEW && out_free) begin
      out_data.left_drive  <= DRV_W'(l_next);
      out_data.right_drive <= DRV_W'(r_next);
      out_data.moving      <= !(still_next > 3'd4);
    end
  end

  // ---------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------
  a_still_sat: assert property (@(posedge clk) disable iff (rst)
    still_count <= 3'd5)
    else $error("still count beyond saturation");

  a_speed_range: assert property (@(posedge clk) disable iff (rst)
    left_speed != -(DRV_W'(1) <<< (DRV_W - 1)) &&
    right_speed != -(DRV_W'(1) <<< (DRV_W - 1)))
    else $error("drive command out of range");

  a_mul_count: assert property (@(posedge clk) disable iff (rst)
    (state == pdsl_pkg::S_MULP || state == pdsl_pkg::S_MULD ||
     state == pdsl_pkg::S_SCALE) |-> cnt < CNT_W'(GAIN_W))
    else $error("multiplier ran past gain width");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == pdsl_pkg::S_PREP)
    else $error("accepted tick not started");

endmodule
